// ===== rtl/rfp_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the radio frame parser.
package rfp_pkg;

    localparam int HdrLen   = 13;
    localparam int MinFrame = 16;
    localparam logic [15:0] CrcPoly = 16'h1021;

    typedef logic [3:0] t_hdr_idx;
    typedef logic [HdrLen-1:0][7:0] t_hdr_bytes;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_SHORT   = 2'd2
    } t_status;

    typedef struct packed {
        logic     clr;
        logic     en;
        t_hdr_idx idx;
        logic [7:0] data;
    } t_hdr_wr;

    typedef struct packed {
        logic        valid;
        logic        is_summary;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [15:0] frame_control;
        logic [7:0]  sequence_number;
        logic [15:0] dest_pan;
        logic [15:0] dest_address;
        logic [15:0] source_pan;
        logic [15:0] source_address;
        logic [7:0]  frame_type;
        logic [7:0]  payload_size;
        logic [7:0]  frame_length;
    } t_result;

    // One byte of CRC-16 (poly 0x1021, MSB first), eight shift steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/rfp_hdr_store.sv =====
// Header byte registers, written one byte per beat and cleared at frame start.
module rfp_hdr_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfp_pkg::t_hdr_wr   i_wr,
    output rfp_pkg::t_hdr_bytes o_hdr
);
    import rfp_pkg::*;

    t_hdr_bytes r_hdr;
    t_hdr_bytes n_hdr;

    always_comb begin
        n_hdr = r_hdr;
        if (i_wr.clr) begin
            n_hdr = '0;
        end else if (i_wr.en) begin
            for (int k = 0; k < HdrLen; k++) begin
                if (i_wr.idx == t_hdr_idx'(k)) begin
                    n_hdr[k] = i_wr.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else begin
            r_hdr <= n_hdr;
        end
    end

    assign o_hdr = r_hdr;

endmodule

// ===== rtl/rfp_parse_core.sv =====
// Frame tracking state, running CRC and result decision for one received byte.
module rfp_parse_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data,
    input  logic                i_start,
    input  rfp_pkg::t_hdr_bytes i_hdr,
    output rfp_pkg::t_hdr_wr    o_hdr_wr,
    output rfp_pkg::t_result    o_result
);
    import rfp_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;

    logic [7:0]  p8;
    logic [8:0]  p9;
    logic [8:0]  n9;
    logic        body;

    function automatic t_result make_summary(input t_hdr_bytes h, input t_status st,
                                             input logic [7:0] len);
        t_result r;
        r                 = '0;
        r.valid           = 1'b1;
        r.is_summary      = 1'b1;
        r.frame_status    = st;
        r.frame_control   = {h[0], h[1]};
        r.sequence_number = h[2];
        r.dest_pan        = {h[3], h[4]};
        r.dest_address    = {h[5], h[6]};
        r.source_pan      = {h[7], h[8]};
        r.source_address  = {h[9], h[10]};
        r.frame_type      = h[11];
        r.payload_size    = h[12];
        r.frame_length    = len;
        return r;
    endfunction

    assign p8   = r_pos + 8'd1;
    assign p9   = {1'b0, r_pos} + 9'd1;
    assign n9   = {1'b0, r_len};
    // Bytes ahead of the two CRC bytes are covered by the CRC.
    assign body = (p9 + 9'd3) <= n9;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        o_hdr_wr   = '0;
        o_result   = '0;
        if (i_step) begin
            if (i_start) begin
                n_len         = i_data - 8'd1;
                n_pos         = '0;
                n_crc_hi      = '0;
                n_crc         = crc16_byte(16'h0000, i_data);
                o_hdr_wr.clr  = 1'b1;
                if (n_len <= 8'd1) begin
                    // Empty or one-byte frame closes on its own length byte.
                    n_in_frame = 1'b0;
                    o_result   = make_summary('0, ST_SHORT, n_len);
                end else begin
                    n_in_frame = 1'b1;
                end
            end else if (r_in_frame) begin
                n_pos = p8;
                if (body) begin
                    n_crc = crc16_byte(r_crc, i_data);
                    if (p9 <= 9'(HdrLen)) begin
                        o_hdr_wr.en   = 1'b1;
                        o_hdr_wr.idx  = t_hdr_idx'(p8 - 8'd1);
                        o_hdr_wr.data = i_data;
                    end else begin
                        o_result.valid        = 1'b1;
                        o_result.payload_byte = i_data;
                    end
                end else if ((p9 + 9'd2) == n9) begin
                    n_crc_hi = i_data;
                end else begin
                    n_in_frame = 1'b0;
                    if (r_len < 8'(MinFrame)) begin
                        o_result = make_summary(i_hdr, ST_SHORT, r_len);
                    end else if ({r_crc_hi, i_data} == r_crc) begin
                        o_result = make_summary(i_hdr, ST_OK, r_len);
                    end else begin
                        o_result = make_summary(i_hdr, ST_CRC_ERR, r_len);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_crc      <= '0;
            r_crc_hi   <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
        end
    end

endmodule

// ===== rtl/radio_frame_parser_crc16_check.sv =====
// Top level of the receive frame parser with CRC-16/XMODEM check.
//
// Input channel (i_valid / o_ready) carries one received byte per beat plus a
// start flag that marks the length byte of a new frame. Output channel
// (o_valid / i_ready) carries one result per beat: either a payload byte or an
// end-of-frame summary with the header fields, the frame length and a status
// of ok, CRC mismatch or too short.
// A byte is registered on acceptance and processed when it advances from the input
// register; its result, if any, is registered in the output register. One byte is
// taken every cycle while the output is not stalled; the whole CRC byte update sits
// between the input register and the running CRC register.
// When the receiver stalls, the output register holds its result and the input
// register holds the next byte; o_ready drops once both are full and rises in
// the cycle that the output is taken. Bytes that yield no result still wait
// for a free output slot.
// Reset (synchronous, active low) empties both registers, closes any open
// frame and clears the running CRC and stored header.
module radio_frame_parser_crc16_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_summary,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_frame_control,
    output logic [7:0]  o_sequence_number,
    output logic [15:0] o_dest_pan,
    output logic [15:0] o_dest_address,
    output logic [15:0] o_source_pan,
    output logic [15:0] o_source_address,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_payload_size,
    output logic [7:0]  o_frame_length
);
    import rfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_start;
    logic       r_out_valid;
    t_result    r_out;

    logic       adv;
    t_hdr_wr    hdr_wr;
    t_hdr_bytes hdr;
    t_result    result;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
    end

    rfp_hdr_store u_hdr_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (hdr_wr),
        .o_hdr   (hdr)
    );

    rfp_parse_core u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_data   (r_in_data),
        .i_start  (r_in_start),
        .i_hdr    (hdr),
        .o_hdr_wr (hdr_wr),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.valid) begin
            r_out <= result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_is_summary      = r_out.is_summary;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_frame_status    = r_out.frame_status;
    assign o_frame_control   = r_out.frame_control;
    assign o_sequence_number = r_out.sequence_number;
    assign o_dest_pan        = r_out.dest_pan;
    assign o_dest_address    = r_out.dest_address;
    assign o_source_pan      = r_out.source_pan;
    assign o_source_address  = r_out.source_address;
    assign o_frame_type      = r_out.frame_type;
    assign o_payload_size    = r_out.payload_size;
    assign o_frame_length    = r_out.frame_length;

    // A passing CRC check is only possible on a full-size frame.
    a_ok_needs_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary && (o_frame_status == ST_OK) |->
            (o_frame_length >= 8'(MinFrame)))
        else $error("ok status on a frame shorter than the minimum");

    // Payload beats carry no summary content.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_summary |-> (o_frame_status == ST_OK) && (o_frame_length == 8'd0))
        else $error("payload beat with summary fields set");

    // A byte held in the input register is not lost while the output is blocked.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_data) && $stable(r_in_start))
        else $error("input register changed while stalled");

    // The status code 3 is never produced.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && result.valid |-> (result.frame_status == ST_OK) ||
            (result.frame_status == ST_CRC_ERR) || (result.frame_status == ST_SHORT))
        else $error("undefined frame status");

endmodule
